// File: hw/rtl/swm_pkg.sv
// shared constants and types for the sliding window maximum block
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int PTR_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int DATA_W     = 32;
   localparam int WIN_W      = 7;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
   localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET = 7'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BACK_RD,
      ST_BACK_CMP,
      ST_FRONT_RD,
      ST_FRONT_CMP,
      ST_PUSH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_back;
      logic rd_front;
      logic drop_tail;
      logic drop_head;
      logic keep_head;
      logic push;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic occ_zero;
      logic back_pop;
      logic front_old;
      logic result_due;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/swm_ram.sv
// generic single write, single registered read port ram
`timescale 1ns / 1ps
`default_nettype none
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/swm_datapath.sv
// deque pointers, counters, ram, csr and result register
`timescale 1ns / 1ps
`default_nettype none
module swm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire swm_pkg::cmd_type                    cmd,
   output swm_pkg::status_type                      status,
   input  wire logic [swm_pkg::DATA_W-1:0]          req_tdata,
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [swm_pkg::DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [swm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic      [31:0]                         csr_prdata
);
   import swm_pkg::*;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WINDOW_MAX);

   logic [WIN_W-1:0]  window_size_ff, window_size_in;
   logic [PTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  occ_ff, occ_in, seen_ff, seen_in;
   logic [DATA_W-1:0] position_ff, position_in;
   logic [DATA_W-1:0] sample_ff, sample_in;
   logic [DATA_W-1:0] head_val_ff, head_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PTR_W-1:0]    tail_prev, tail_next, head_next, rd_addr;
   logic [CNT_W-1:0]    win_eff;
   logic [2*DATA_W-1:0] rd_data;
   logic [DATA_W-1:0]   rd_val, rd_pos, age;
   logic                csr_wr;

   assign tail_prev = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;
   assign tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;

   // window above the deque depth is clamped to the depth
   always_comb begin
      if (CNT_W'(window_size_ff) > CNT_MAX) begin
         win_eff = CNT_MAX;
      end else begin
         win_eff = CNT_W'(window_size_ff);
      end
   end

   assign rd_addr = cmd.rd_back ? tail_prev : head_ff;

   swm_ram #(
      .WIDTH(2 * DATA_W),
      .DEPTH(WINDOW_MAX)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.push),
      .wr_addr(tail_ff),
      .wr_data({position_ff, sample_ff}),
      .rd_en  (cmd.rd_back | cmd.rd_front),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_val = rd_data[DATA_W-1:0];
   assign rd_pos = rd_data[2*DATA_W-1:DATA_W];
   assign age    = position_ff - rd_pos;

   assign status.occ_zero   = (occ_ff == '0);
   assign status.back_pop   = !($signed(rd_val) > $signed(sample_ff));
   assign status.front_old  = (age >= DATA_W'(win_eff));
   assign status.result_due = (win_eff != '0) && (seen_ff >= win_eff);
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      window_size_in = window_size_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      seen_in        = seen_ff;
      position_in    = position_ff;
      sample_in      = sample_ff;
      head_val_in    = head_val_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (csr_wr && (csr_paddr[2] == REG_WINDOW_SIZE)) begin
         window_size_in = csr_pwdata[WIN_W-1:0];
      end

      if (cmd.load) begin
         sample_in = req_tdata;
         if (req_tuser) begin
            head_in     = '0;
            tail_in     = '0;
            occ_in      = '0;
            seen_in     = '0;
            position_in = '0;
         end
      end

      if (cmd.drop_tail) begin
         tail_in = tail_prev;
         occ_in  = occ_ff - 1'b1;
      end

      if (cmd.drop_head) begin
         head_in = head_next;
         occ_in  = occ_ff - 1'b1;
      end

      if (cmd.keep_head) begin
         head_val_in = rd_val;
      end

      if (cmd.push) begin
         tail_in     = tail_next;
         occ_in      = occ_ff + 1'b1;
         position_in = position_ff + 1'b1;
         if (seen_ff < CNT_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
         // empty deque: the new sample becomes the front
         if (occ_ff == '0) begin
            head_val_in = sample_ff;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = head_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         occ_ff         <= '0;
         seen_ff        <= '0;
         position_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         occ_ff         <= occ_in;
         seen_ff        <= seen_in;
         position_ff    <= position_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      head_val_ff <= head_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_SIZE) ?
                       {{(32 - WIN_W){1'b0}}, window_size_ff} : 32'd0;

endmodule
`default_nettype wire

// File: hw/rtl/swm_ctrl.sv
// sequencer for back pops, front pops, push and result transfer
`timescale 1ns / 1ps
`default_nettype none
module swm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire swm_pkg::status_type status,
   output swm_pkg::cmd_type         cmd
);
   import swm_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_BACK_RD;
            end
         end
         ST_BACK_RD: begin
            state_in = status.occ_zero ? ST_FRONT_RD : ST_BACK_CMP;
         end
         ST_BACK_CMP: begin
            state_in = status.back_pop ? ST_BACK_RD : ST_FRONT_RD;
         end
         ST_FRONT_RD: begin
            state_in = status.occ_zero ? ST_PUSH : ST_FRONT_CMP;
         end
         ST_FRONT_CMP: begin
            state_in = status.front_old ? ST_FRONT_RD : ST_PUSH;
         end
         ST_PUSH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!status.result_due || !status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_BACK_RD: begin
            cmd.rd_back = !status.occ_zero;
         end
         ST_BACK_CMP: begin
            cmd.drop_tail = status.back_pop;
         end
         ST_FRONT_RD: begin
            cmd.rd_front = !status.occ_zero;
         end
         ST_FRONT_CMP: begin
            cmd.drop_head = status.front_old;
            cmd.keep_head = !status.front_old;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
         end
         ST_OUT: begin
            cmd.emit = status.result_due && !status.out_busy;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/sliding_window_maximum.sv
// Sliding window maximum over a stream of signed 32-bit samples.
// req channel: req_tdata carries the sample, req_tuser marks the first sample of a
// new sequence (clears the deque, the position and the warm-up count).
// rsp channel: rsp_tdata carries the maximum of the last window_size samples; one
// transfer per sample once window_size samples of the sequence have arrived, none
// while warming up or when window_size is zero. Sizes above 64 act as 64.
// csr port: register window_size at address 0 (7 bits, reset value 3); the user must
// write it only while the block is idle, the block itself does not enforce this.
// One sample is processed at a time. After its transfer a sample goes through a back
// scan that pops entries not above it, then a front scan that pops entries that fell
// out of the window, then the push and the output step; each sample is pushed once
// and popped at most once. The deque ram has a single read port, so each pop needs
// a read of the entry and then a compare.
// The result sits in an output register; if rsp_tready is low when the next
// result is ready, the block holds it and takes no new sample until it moves.
// Reset clears the deque, counters and rsp_tvalid and sets window_size to 3; the ram
// needs no clearing, only occupied entries are read.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_maximum (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [swm_pkg::DATA_W-1:0]     req_tdata,   // [31:0] sample
   input  wire logic                           req_tuser,   // [0] first
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [swm_pkg::DATA_W-1:0]     rsp_tdata,   // [31:0] window_max
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [swm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);
   import swm_pkg::*;

   cmd_type    cmd;
   status_type status;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata)
   );

   assign csr_pready = 1'b1;

endmodule
`default_nettype wire

// File: hw/rtl/swm_checker.sv
// port-level checks for the sliding window maximum block
`timescale 1ns / 1ps
`default_nettype none
module swm_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [swm_pkg::DATA_W-1:0]     rsp_tdata,
   input  wire logic                           csr_psel,
   input  wire logic [31:0]                    csr_prdata,
   input  wire logic                           csr_pready
);
   import swm_pkg::*;

   // a result waiting on the receiver keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one sample at a time: no transfer in the cycle after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample taken while another is in work");

   // reset leaves no result pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // window_size readback is only 7 bits wide and the port never stalls
   a_csr_read: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready && (csr_prdata[31:WIN_W] == '0))
      else $error("bad register readback");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);
`default_nettype wire

// File: tb/tb_sliding_window_maximum.sv
// self-checking testbench for the sliding window maximum block
`timescale 1ns / 1ps
`default_nettype none
module tb_sliding_window_maximum;
   import swm_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int SETTLE_CYCLES = 300;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_PHASES    = 11;
   localparam int PHASE_ITEMS   = 180;
   localparam int ZERO_ITEMS    = 60;
   localparam int NUM_DIRECTED  = 21;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_SIZE_ADDR = {REG_WINDOW_SIZE, 2'b00};

   localparam logic [DATA_W-1:0] DIR_SAMPLES [NUM_DIRECTED] = '{
      32'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd2,
      32'd3, 32'd4, 32'd40, 32'd30, 32'd20,
      32'd10, 32'hFFFF_FFFB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
      32'hAAAA_AAAA
   };
   localparam bit DIR_FIRST [NUM_DIRECTED] = '{
      0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0
   };

   typedef enum int {
      SEQ_RANDOM,
      SEQ_NARROW,
      SEQ_RISING,
      SEQ_FALLING,
      SEQ_EXTREME
   } seq_kind_type;

   // running model of the deque and the queue of window maxima it predicts
   class WindowMaxTracker;
      logic [DATA_W-1:0] slot_value [WINDOW_MAX];
      logic [31:0]       slot_pos [WINDOW_MAX];
      int                head;
      int                tail;
      int                count;
      logic [31:0]       next_pos;
      int                seq_len;
      logic [WIN_W-1:0]  window;
      logic [DATA_W-1:0] max_queue [$];
      int                failures;

      function new(logic [WIN_W-1:0] init_window);
         head = 0;
         tail = 0;
         count = 0;
         next_pos = '0;
         seq_len = 0;
         window = init_window;
         failures = 0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void set_window(logic [WIN_W-1:0] value);
         window = value;
      endfunction

      function void note_sample(logic [DATA_W-1:0] sample, logic first);
         int unsigned span;
         int unsigned age;
         int          back;
         span = (window > WINDOW_MAX) ? WINDOW_MAX : window;
         if (first) begin
            head = 0;
            tail = 0;
            count = 0;
            next_pos = '0;
            seq_len = 0;
         end
         // drop back entries that the new sample dominates
         while (count > 0) begin
            back = (tail == 0) ? WINDOW_MAX - 1 : tail - 1;
            if ($signed(slot_value[back]) > $signed(sample)) break;
            tail = back;
            count--;
         end
         // drop front entries that fell out of the window
         while (count > 0) begin
            age = next_pos - slot_pos[head];
            if (age < span) break;
            head = (head + 1) % WINDOW_MAX;
            count--;
         end
         if (count >= WINDOW_MAX) begin
            head = (head + 1) % WINDOW_MAX;
            count--;
         end
         slot_value[tail] = sample;
         slot_pos[tail] = next_pos;
         tail = (tail + 1) % WINDOW_MAX;
         count++;
         next_pos = next_pos + 1;
         if (seq_len < WINDOW_MAX) seq_len++;
         if (span != 0 && seq_len >= span) max_queue = {max_queue, slot_value[head]};
      endfunction

      function void check_max(logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         if (max_queue.size() == 0) begin
            flag($sformatf("unexpected window_max %0d", $signed(got)));
         end else begin
            want = max_queue[0];
            max_queue.delete(0);
            if (got !== want)
               flag($sformatf("window_max mismatch: expected %0d got %0d",
                              $signed(want), $signed(got)));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;    // [31:0] sample
   logic                  req_tuser = 1'b0;  // [0] first
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;         // [31:0] window_max
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   WindowMaxTracker sb;
   bit req_gaps_on = 1'b0;
   bit rsp_gaps_on = 1'b0;
   int rsp_hold_cycles = 0;

   sliding_window_maximum u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_HALF) clock = ~clock;

   initial begin
      #(20_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_sample(input logic [DATA_W-1:0] sample, input logic first);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(sample, first);
   endtask

   // stop offering and let every predicted result arrive
   task automatic wait_drained(input int settle);
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (sb.max_queue.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= WINDOW_SIZE_ADDR;
      csr_pwdata <= {{(32-WIN_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_window(value);
      // read back in the following transfer
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {{(32-WIN_W){1'b0}}, value})
         sb.flag($sformatf("window_size readback: expected %0d got %0d", value, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input int n_items, input bit pause_mid);
      int           sent;
      int           len;
      int           span;
      seq_kind_type kind;
      logic [31:0]  trend;
      logic [31:0]  sample;
      logic         first;
      bit           paused;
      sent = 0;
      paused = 1'b0;
      span = (sb.window > WINDOW_MAX) ? WINDOW_MAX : sb.window;
      while (sent < n_items) begin
         len = $urandom_range(1, 2 * span + 24);
         kind = seq_kind_type'($urandom_range(0, 4));
         trend = $urandom;
         first = ($urandom_range(0, 9) != 0);
         for (int i = 0; i < len && sent < n_items; i++) begin
            case (kind)
               SEQ_RANDOM:  sample = $urandom;
               SEQ_NARROW:  sample = $urandom_range(0, 8) - 4;
               SEQ_RISING: begin
                  trend = trend + $urandom_range(0, 3);
                  sample = trend;
               end
               SEQ_FALLING: begin
                  trend = trend - $urandom_range(0, 3);
                  sample = trend;
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0:       sample = 32'h8000_0000;
                     1:       sample = 32'h7FFF_FFFF;
                     2:       sample = 32'h0000_0000;
                     default: sample = 32'hFFFF_FFFF;
                  endcase
               end
            endcase
            send_sample(sample, (i == 0) ? first : 1'b0);
            sent++;
            if (pause_mid && !paused && sent >= n_items / 2) begin
               paused = 1'b1;
               wait_drained(0);
            end
         end
      end
   endtask

   // result side: random stalls, one long hold on request
   initial begin
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = rsp_gaps_on ? $urandom_range(0, 14) : 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_max(rsp_tdata);
      end
   end

   initial begin
      logic [WIN_W-1:0] win;
      sb = new(WINDOW_SIZE_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset window size
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      for (int i = 0; i < NUM_DIRECTED; i++) send_sample(DIR_SAMPLES[i], DIR_FIRST[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       win = 7'd1;
            1:       win = 7'd0;
            2:       win = 7'd64;
            3:       win = 7'd127;
            4:       win = 7'd65;
            5:       win = 7'd2;
            6:       win = 7'd5;
            7:       win = 7'd17;
            8:       win = 7'd63;
            default: win = $urandom_range(0, 127);
         endcase
         wait_drained(SETTLE_CYCLES);
         write_window(win);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         if (p == 2) begin
            // receiver stalls while the sender keeps offering back to back
            req_gaps_on = 1'b0;
            rsp_hold_cycles = HOLD_CYCLES;
         end
         run_phase((win == 0) ? ZERO_ITEMS : PHASE_ITEMS, p == 5);
      end

      wait_drained(SETTLE_CYCLES);
      if (sb.max_queue.size() != 0)
         $display("%0d expected results never arrived", sb.max_queue.size());
      if (sb.failures == 0 && sb.max_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
